// ===== rtl/set_assoc_cache_tag_lookup_macros.svh =====
// assertion macros for the tag lookup block
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SACT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SACT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// sact_pkg
// constants and types shared by the cache tag lookup block
// ----------------------------------------------------------------------------
`default_nettype none
package sact_pkg;
  localparam int WAYS = 16;
  localparam int SETS = 256;
  localparam int BLOCK_OFFSET_BITS = 5;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_BITS = $clog2(SETS);
  localparam int TAG_W = 32 - BLOCK_OFFSET_BITS - SET_BITS;
  localparam int EV_TAG_W = 19;
  localparam int CLR_W = SET_W + 1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_RAND = 2'd1;
  localparam logic [1:0] POL_NMRU = 2'd2;
  localparam logic [0:0] REG_POLICY = 1'b0;
  localparam logic [0:0] REG_SEED = 1'b1;

  typedef logic [WAYS-1:0]             valid_row_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [WAYS-1:0][WAY_W-1:0]  rank_row_t;
endpackage
`default_nettype wire

// ===== rtl/set_assoc_cache_tag_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// set-associative tag lookup with lru, random and not-mru replacement
// ----------------------------------------------------------------------------
// An address is taken when start is high and busy is low. Each set lives in
// one row of three memories (valid, tags, recency ranks). The row is read at
// the edge that takes the address and the updated row is written back at the
// next edge; busy is high while the word is looked up, so no new word is
// taken before the write-back. The result is shown with done high for one cycle,
// the cycle after the write-back, and cannot be held off. After reset a
// clearing pass walks every set of the valid and rank memories while busy
// stays high. Configuration writes belong in cycles with no word in flight.
`default_nettype none
`include "set_assoc_cache_tag_lookup_macros.svh"
module set_assoc_cache_tag_lookup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] address,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             done,
  output logic             hit,
  output logic [3:0]       way,
  output logic             evicted_valid,
  output logic [18:0]      evicted_tag
);
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  sact_pkg::valid_row_t valid_mem [sact_pkg::SETS];
  sact_pkg::tag_row_t   tag_mem   [sact_pkg::SETS];
  sact_pkg::rank_row_t  rank_mem  [sact_pkg::SETS];

  logic [1:0] state;
  logic [sact_pkg::CLR_W-1:0] clr_cnt;
  logic [1:0]  policy;
  logic [15:0] lfsr;
  logic [sact_pkg::SET_W-1:0] last_set, cur_set;
  logic [sact_pkg::WAY_W-1:0] last_way;
  logic        last_known;
  logic [sact_pkg::TAG_W-1:0] cur_tag;
  sact_pkg::valid_row_t rd_valid;
  sact_pkg::tag_row_t   rd_tag;
  sact_pkg::rank_row_t  rd_rank;

  logic [sact_pkg::SET_W-1:0] in_set;
  assign in_set = (sact_pkg::SETS > 1) ?
    sact_pkg::SET_W'(address >> sact_pkg::BLOCK_OFFSET_BITS) : '0;

  // lookup on the registered row
  logic hit_c, have_inv;
  logic [sact_pkg::WAY_W-1:0] hit_way, inv_way, lru_way, rnd_way, sel_way;
  logic [15:0] lfsr_step;
  logic        ev_c;
  always_comb begin
    hit_c = 1'b0; have_inv = 1'b0; hit_way = '0; inv_way = '0;
    lru_way = '0;
    for (int i = 0; i < sact_pkg::WAYS; i++) begin
      if (!rd_valid[i]) begin
        have_inv = 1'b1;
        inv_way = sact_pkg::WAY_W'(i);
      end else if (!hit_c && rd_tag[i] == cur_tag) begin
        hit_c = 1'b1;
        hit_way = sact_pkg::WAY_W'(i);
      end
      // ranks of a set are a permutation, so the oldest way holds the top rank
      if (rd_rank[i] == sact_pkg::WAY_W'(sact_pkg::WAYS - 1))
        lru_way = sact_pkg::WAY_W'(i);
    end
    lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ sact_pkg::LFSR_MASK) : (lfsr >> 1);
    rnd_way = sact_pkg::WAY_W'(32'(lfsr_step) % sact_pkg::WAYS);
    if (policy == sact_pkg::POL_NMRU && sact_pkg::WAYS > 1 && last_known &&
        last_set == cur_set && last_way == rnd_way)
      rnd_way = sact_pkg::WAY_W'((32'(rnd_way) + 1) % sact_pkg::WAYS);
    ev_c = !hit_c && !have_inv;
    if (hit_c) sel_way = hit_way;
    else if (have_inv) sel_way = inv_way;
    else if (policy == sact_pkg::POL_RAND || policy == sact_pkg::POL_NMRU)
      sel_way = rnd_way;
    else sel_way = lru_way;
  end

  logic use_rnd;
  assign use_rnd = ev_c && (policy == sact_pkg::POL_RAND || policy == sact_pkg::POL_NMRU);

  sact_pkg::valid_row_t wr_valid;
  sact_pkg::tag_row_t   wr_tag;
  sact_pkg::rank_row_t  wr_rank;
  always_comb begin
    wr_valid = rd_valid;
    wr_tag = rd_tag;
    wr_rank = rd_rank;
    wr_valid[sel_way] = 1'b1;
    wr_tag[sel_way] = cur_tag;
    for (int i = 0; i < sact_pkg::WAYS; i++)
      if (rd_rank[i] < rd_rank[sel_way]) wr_rank[i] = rd_rank[i] + 1'b1;
    wr_rank[sel_way] = '0;
  end

  sact_pkg::rank_row_t init_rank;
  always_comb begin
    for (int i = 0; i < sact_pkg::WAYS; i++) init_rank[i] = sact_pkg::WAY_W'(i);
  end

  // memories
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      valid_mem[clr_cnt[sact_pkg::SET_W-1:0]] <= '0;
      rank_mem[clr_cnt[sact_pkg::SET_W-1:0]] <= init_rank;
    end else if (state == ST_LOOK) begin
      valid_mem[cur_set] <= wr_valid;
      tag_mem[cur_set] <= wr_tag;
      rank_mem[cur_set] <= wr_rank;
    end
    rd_valid <= valid_mem[in_set];
    rd_tag <= tag_mem[in_set];
    rd_rank <= rank_mem[in_set];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      policy <= sact_pkg::POL_LRU;
      lfsr <= 16'd1;
      last_set <= '0;
      last_way <= '0;
      last_known <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (state == ST_LOOK);
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == sact_pkg::CLR_W'(sact_pkg::SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) state <= ST_LOOK;
        end
        ST_LOOK: begin
          state <= ST_IDLE;
          last_set <= cur_set;
          last_way <= sel_way;
          last_known <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_we && cfg_index == sact_pkg::REG_SEED)
        lfsr <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      else if (state == ST_LOOK && use_rnd)
        lfsr <= lfsr_step;
      if (cfg_we && cfg_index == sact_pkg::REG_POLICY) policy <= cfg_data[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cur_set <= in_set;
      cur_tag <= address[31 -: sact_pkg::TAG_W];
    end
    if (state == ST_LOOK) begin
      hit <= hit_c;
      way <= 4'(sel_way);
      evicted_valid <= ev_c;
      evicted_tag <= ev_c ? 19'(rd_tag[sel_way]) : '0;
    end
  end

  assign busy = (state != ST_IDLE);

  `SACT_ASSERT(a_done_after_look, clk, rst, done |-> $past(state) == ST_LOOK, "done without lookup")
  `SACT_ASSERT(a_no_ev_on_hit, clk, rst, done |-> !(hit && evicted_valid), "eviction on hit")
  `SACT_ASSERT(a_evtag_zero, clk, rst, (done && !evicted_valid) |-> evicted_tag == '0, "stray evicted tag")
  `SACT_ASSERT(a_lfsr_nonzero, clk, rst, lfsr != 16'd0, "lfsr locked at zero")
endmodule
`default_nettype wire
